@@ design/pfba_pkg.sv @@
// ----------------------------------------------------------------------------
// Page frame bitmap allocator package
// Shared widths, command codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package pfba_pkg;

   // Physical address width and result field widths.
   localparam int ADDR_W    = 52;
   localparam int CMD_W     = 2;
   localparam int USED_W    = 17;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 1;

   // Bitmap byte with every frame marked used.
   localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hff;
   localparam logic [BYTE_W-1:0] BIT_ONE   = 8'h01;

   // Request commands.
   typedef enum logic [CMD_W-1:0] {
      CMD_INIT  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_BASE = 1'b0,
      CSR_REGION_END  = 1'b1
   } csr_index_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_DIV,
      ST_INIT_RSV,
      ST_INIT_CLR,
      ST_SCAN,
      ST_MUL,
      ST_ADD,
      ST_FREE_DIV,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_RESP
   } state_type;

endpackage

@@ design/pfba_if.sv @@
// ----------------------------------------------------------------------------
// Page frame bitmap allocator channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface pfba_req_if;
   import pfba_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ADDR_W-1:0] free_address;

   modport source (output valid, output command, output free_address, input ready);
   modport sink   (input valid, input command, input free_address, output ready);
endinterface

interface pfba_rsp_if;
   import pfba_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] frame_address;
   logic              out_of_memory;
   logic              bad_free;
   logic [USED_W-1:0] used_frames;

   modport source (output valid, output frame_address, output out_of_memory,
                   output bad_free, output used_frames, input ready);
   modport sink   (input valid, input frame_address, input out_of_memory,
                   input bad_free, input used_frames, output ready);
endinterface

@@ design/page_frame_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// Page frame bitmap allocator
// First-fit physical frame allocator with one used bit per frame kept in a
// byte-wide bitmap memory.
//
//   Channel  Direction  Word contents
//   req_ch   in         command, free_address
//   rsp_ch   out        frame_address, out_of_memory, bad_free, used_frames
//   csr_*    in         region_base (index 0), region_end (index 1)
//
// Init runs two divisions and then sweeps the map; allocate scans the map,
// then on a hit multiplies and adds; free divides, then reads and writes one byte,
// and skips the map for an address below the base or past the last frame.
// The map has one read port, so the scan reads one byte per cycle. PAGE_BYTES
// is a power of two, so both divisions are registered shifts.
// Reset clears the controller, region registers and frame counts; the map has no
// clearing pass, since init sweeps every byte that later commands can read.
// A finished word waits in the response register while the next request
// is taken; the controller stalls only when a second word is ready first.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator #(
   parameter int MAX_FRAMES = 65536,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   pfba_req_if.sink                       req_ch,
   pfba_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [pfba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pfba_pkg::ADDR_W-1:0]    csr_wr_data
);
   import pfba_pkg::*;

   localparam int TOTAL_W    = $clog2(MAX_FRAMES + 1);
   localparam int IDX_W      = $clog2(MAX_FRAMES);
   localparam int MAP_BYTES  = (MAX_FRAMES + 7) / 8;
   localparam int MAP_AW     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int BCNT_W     = $clog2(MAP_BYTES + 1);
   localparam int POS_W      = BCNT_W + 4;
   localparam int RSV_DIV    = 8 * PAGE_BYTES;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PB_W       = $clog2(PAGE_BYTES + 1);
   localparam int PROD_W     = IDX_W + PB_W;

   // Controller and allocator state.
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]  region_end_ff, region_end_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [USED_W-1:0]  used_ff, used_in;
   logic [TOTAL_W-1:0] rsv_ff, rsv_in;
   logic [BCNT_W-1:0]  cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [BCNT_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               res_oom_ff, res_oom_in;
   logic               res_bad_ff, res_bad_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic               rsp_oom_ff, rsp_oom_in;
   logic               rsp_bad_ff, rsp_bad_in;
   logic [USED_W-1:0]  rsp_used_ff, rsp_used_in;

   // Divider and map connections.
   logic               div_start;
   logic               div_by_map;
   logic [ADDR_W-1:0]  div_numer;
   logic               div_done;
   logic [ADDR_W-1:0]  div_quo;
   logic               rd_en;
   logic [MAP_AW-1:0]  rd_addr;
   logic [BYTE_W-1:0]  rd_data;
   logic               wr_en;
   logic [MAP_AW-1:0]  wr_addr;
   logic [BYTE_W-1:0]  wr_data;

   // Helper values.
   logic               req_ready;
   logic [ADDR_W-1:0]  span;
   logic [TOTAL_W-1:0] frames_sat;
   logic [BCNT_W-1:0]  nbytes;
   logic [POS_W-1:0]   lo_pos;
   logic [POS_W-1:0]   rsv_pos;
   logic [2:0]         rsv_left;
   logic [BYTE_W-1:0]  clr_byte;
   logic               scan_hit;
   logic [2:0]         zk;
   logic [POS_W-1:0]   idx_pos;
   logic [MAP_AW-1:0]  free_byte;

   pfba_div #(
      .NUM_W (ADDR_W),
      .SHIFT (PAGE_SHIFT)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .by_map   (div_by_map),
      .numer    (div_numer),
      .done     (div_done),
      .quotient (div_quo)
   );

   pfba_map #(
      .DEPTH (MAP_BYTES),
      .AW    (MAP_AW)
   ) u_map (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Configuration writes.
   always_comb begin
      base_in       = base_ff;
      region_end_in = region_end_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_REGION_BASE: begin
               base_in = csr_wr_data;
            end
            CSR_REGION_END: begin
               region_end_in = csr_wr_data;
            end
            default: begin
               base_in = base_ff;
            end
         endcase
      end
   end

   // Region size, saturated frame count and bytes covered by the map.
   always_comb begin
      span       = (region_end_ff > base_ff) ? (region_end_ff - base_ff) : '0;
      frames_sat = (div_quo > ADDR_W'(MAX_FRAMES)) ? TOTAL_W'(MAX_FRAMES)
                                                   : div_quo[TOTAL_W-1:0];
      nbytes     = BCNT_W'((POS_W'(total_ff) + POS_W'(7)) >> 3);
      free_byte  = MAP_AW'(POS_W'(idx_ff) >> 3);
   end

   // Init pattern: leading frames that hold the bitmap are marked used.
   always_comb begin
      lo_pos   = POS_W'(cnt_ff) << 3;
      rsv_pos  = POS_W'(rsv_ff);
      rsv_left = 3'(rsv_pos - lo_pos);
      if (rsv_pos >= lo_pos + POS_W'(8)) begin
         clr_byte = BYTE_FULL;
      end else if (rsv_pos <= lo_pos) begin
         clr_byte = '0;
      end else begin
         clr_byte = (BIT_ONE << rsv_left) - BIT_ONE;
      end
   end

   // Lowest clear bit of the byte returned by the map.
   always_comb begin
      scan_hit = (rd_data != BYTE_FULL);
      zk       = '0;
      for (int k = 7; k >= 0; k--) begin
         if (!rd_data[k]) begin
            zk = 3'(k);
         end
      end
      idx_pos = (POS_W'(pend_addr_ff) << 3) | POS_W'(zk);
   end

   // Controller: next state, map accesses and result staging.
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      used_in      = used_ff;
      rsv_in       = rsv_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      res_addr_in  = res_addr_ff;
      res_oom_in   = res_oom_ff;
      res_bad_in   = res_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_oom_in   = rsp_oom_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_used_in  = rsp_used_ff;
      div_start    = 1'b0;
      div_by_map   = 1'b0;
      div_numer    = span;
      rd_en        = 1'b0;
      rd_addr      = cnt_ff[MAP_AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = cnt_ff[MAP_AW-1:0];
      wr_data      = clr_byte;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               res_addr_in = '0;
               res_oom_in  = 1'b0;
               res_bad_in  = 1'b0;
               case (cmd_type'(req_ch.command))
                  CMD_INIT: begin
                     div_start = 1'b1;
                     div_numer = span;
                     state_in  = ST_INIT_DIV;
                  end
                  CMD_ALLOC: begin
                     cnt_in   = '0;
                     state_in = ST_SCAN;
                  end
                  CMD_FREE: begin
                     if (req_ch.free_address < base_ff) begin
                        res_bad_in = 1'b1;
                        state_in   = ST_RESP;
                     end else begin
                        div_start = 1'b1;
                        div_numer = req_ch.free_address - base_ff;
                        state_in  = ST_FREE_DIV;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_INIT_DIV: begin
            // Frame count known: start the reserved-frame division.
            if (div_done) begin
               total_in   = frames_sat;
               used_in    = '0;
               div_start  = 1'b1;
               div_by_map = 1'b1;
               div_numer  = ADDR_W'(frames_sat) + ADDR_W'(RSV_DIV - 1);
               state_in   = ST_INIT_RSV;
            end
         end
         ST_INIT_RSV: begin
            if (div_done) begin
               rsv_in   = div_quo[TOTAL_W-1:0];
               cnt_in   = '0;
               state_in = ST_INIT_CLR;
            end
         end
         ST_INIT_CLR: begin
            // Sweep the covered bytes, one per cycle.
            if (cnt_ff < nbytes) begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff[MAP_AW-1:0];
               wr_data = clr_byte;
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            // Reads are issued every cycle; the byte read last cycle is checked.
            if (pend_ff && scan_hit) begin
               if (idx_pos >= POS_W'(total_ff)) begin
                  res_oom_in = 1'b1;
                  state_in   = ST_RESP;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = pend_addr_ff[MAP_AW-1:0];
                  wr_data  = rd_data | (BIT_ONE << zk);
                  used_in  = used_ff + USED_W'(1);
                  idx_in   = idx_pos[IDX_W-1:0];
                  state_in = ST_MUL;
               end
            end else if (cnt_ff < nbytes) begin
               rd_en        = 1'b1;
               rd_addr      = cnt_ff[MAP_AW-1:0];
               cnt_in       = cnt_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = cnt_ff;
            end else if (!pend_ff) begin
               res_oom_in = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(idx_ff) * PROD_W'(PAGE_BYTES);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            res_addr_in = base_ff + ADDR_W'(prod_ff);
            state_in    = ST_RESP;
         end
         ST_FREE_DIV: begin
            if (div_done) begin
               if (div_quo >= ADDR_W'(total_ff)) begin
                  res_bad_in = 1'b1;
                  state_in   = ST_RESP;
               end else begin
                  idx_in   = div_quo[IDX_W-1:0];
                  state_in = ST_FREE_RD;
               end
            end
         end
         ST_FREE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = free_byte;
            state_in = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            wr_en   = 1'b1;
            wr_addr = free_byte;
            wr_data = rd_data & ~(BIT_ONE << idx_ff[2:0]);
            if (used_ff != '0) begin
               used_in = used_ff - USED_W'(1);
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // Load the response register once it is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_oom_in   = res_oom_ff;
               rsp_bad_in   = res_bad_ff;
               rsp_used_in  = used_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and allocator registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         base_ff       <= '0;
         region_end_ff <= '0;
         total_ff      <= '0;
         used_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         region_end_ff <= region_end_in;
         total_ff      <= total_in;
         used_ff       <= used_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsv_ff       <= rsv_in;
      cnt_ff       <= cnt_in;
      pend_addr_ff <= pend_addr_in;
      idx_ff       <= idx_in;
      prod_ff      <= prod_in;
      res_addr_ff  <= res_addr_in;
      res_oom_ff   <= res_oom_in;
      res_bad_ff   <= res_bad_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_oom_ff   <= rsp_oom_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_used_ff  <= rsp_used_in;
   end

   // Port drivers.
   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.frame_address = rsp_addr_ff;
   assign rsp_ch.out_of_memory = rsp_oom_ff;
   assign rsp_ch.bad_free      = rsp_bad_ff;
   assign rsp_ch.used_frames   = rsp_used_ff;

`ifndef NO_ASSERTIONS
   // The frame count never exceeds the bitmap capacity.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOTAL_W'(MAX_FRAMES))
      else $error("frame count exceeds bitmap capacity");

   // The divider only finishes while the controller waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_INIT_DIV || state_ff == ST_INIT_RSV ||
                    state_ff == ST_FREE_DIV))
      else $error("divider finished outside a divide state");

   // The map is written only by the init sweep, an allocation or a free.
   a_map_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_INIT_CLR || state_ff == ST_SCAN ||
                 state_ff == ST_FREE_WR))
      else $error("bitmap written in an unexpected state");

   // A finished command with a free response register is offered on the channel next cycle.
   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("response not loaded");
`endif

endmodule

@@ design/pfba_div.sv @@
// ----------------------------------------------------------------------------
// Page frame bitmap allocator divider
// Registered division by the page size, or by the frames that one map page
// covers, for a page size that is a power of two; shared by init and free.
// ----------------------------------------------------------------------------
module pfba_div #(
   parameter int NUM_W = 52,
   parameter int SHIFT = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             by_map,
   input  logic [NUM_W-1:0] numer,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   logic             done_ff, done_in;
   logic [NUM_W-1:0] quo_ff, quo_in;

   // Both divisors are powers of two, so the quotient is a shift.
   always_comb begin
      done_in = start;
      quo_in  = quo_ff;
      if (start) begin
         if (by_map) begin
            quo_in = numer >> (SHIFT + 3);
         end else begin
            quo_in = numer >> SHIFT;
         end
      end
   end

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   // Datapath register.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/pfba_map.sv @@
// ----------------------------------------------------------------------------
// Page frame bitmap allocator map memory
// Byte-wide frame bitmap, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pfba_map #(
   parameter int DEPTH = 8192,
   parameter int AW    = 13
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [pfba_pkg::BYTE_W-1:0] rd_data,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [pfba_pkg::BYTE_W-1:0] wr_data
);
   import pfba_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/sv/pfba_checker.sv @@
// ----------------------------------------------------------------------------
// Page frame bitmap allocator checker
// Watches the request, response and register ports. Each accepted request
// word is run through a bit-level prediction of the frame map, and each
// accepted response word is compared field by field with the oldest
// prediction. The failure count and the number of outstanding words go to
// the test top.
// ----------------------------------------------------------------------------
module pfba_checker #(
   parameter int MAX_FRAMES = 65536,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   pfba_req_if                            req_ch,
   pfba_rsp_if                            rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [pfba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pfba_pkg::ADDR_W-1:0]    csr_wr_data,
   output int                             error_count,
   output int                             open_words
);
   import pfba_pkg::*;

   localparam int MAP_BYTES = (MAX_FRAMES + 7) / 8;

   typedef struct packed {
      logic [ADDR_W-1:0] frame_address;
      logic              out_of_memory;
      logic              bad_free;
      logic [USED_W-1:0] used_frames;
   } rsp_word_type;

   // Shadow copy of the allocator state and its registers.
   logic [BYTE_W-1:0] shadow_map [MAP_BYTES];
   logic [63:0]       shadow_total;
   logic [63:0]       shadow_used;
   logic [63:0]       shadow_base;
   logic [63:0]       shadow_end;

   // Predicted response words, oldest first.
   rsp_word_type      pending_words [$];

   // Rebuild the map for the current region and reserve the frames that
   // hold the map itself.
   function automatic void rebuild_map();
      logic [63:0] frames;
      logic [63:0] reserved;
      frames = '0;
      if (shadow_end > shadow_base) begin
         frames = (shadow_end - shadow_base) / PAGE_BYTES;
      end
      if (frames > MAX_FRAMES) begin
         frames = 64'(MAX_FRAMES);
      end
      shadow_total = frames;
      shadow_used  = '0;
      for (int b = 0; b < MAP_BYTES; b++) begin
         shadow_map[b] = '0;
      end
      reserved = ((frames + 7) / 8 + PAGE_BYTES - 1) / PAGE_BYTES;
      for (logic [63:0] i = 0; i < reserved && i < frames; i++) begin
         shadow_map[i >> 3][i[2:0]] = 1'b1;
      end
   endfunction

   // Apply one request word to the shadow state and return the response.
   function automatic rsp_word_type predict_response(cmd_type cmd,
                                                     logic [ADDR_W-1:0] addr);
      rsp_word_type w;
      logic [63:0]  nbytes;
      logic [63:0]  idx;
      logic         done;
      w    = '0;
      done = 1'b0;
      case (cmd)
         CMD_INIT: begin
            rebuild_map();
         end
         // First fit: lowest clear bit below the frame count.
         CMD_ALLOC: begin
            w.out_of_memory = 1'b1;
            nbytes = (shadow_total + 7) / 8;
            for (logic [63:0] b = 0; b < nbytes && b < MAP_BYTES && !done; b++) begin
               if (shadow_map[b] != BYTE_FULL) begin
                  for (int k = 0; k < BYTE_W && !done; k++) begin
                     idx = b * 8 + k;
                     if (idx >= shadow_total) begin
                        done = 1'b1;
                     end else if (!shadow_map[b][k]) begin
                        shadow_map[b][k] = 1'b1;
                        shadow_used      = (shadow_used + 1) & 64'h1ffff;
                        w.frame_address  = ADDR_W'(shadow_base + idx * PAGE_BYTES);
                        w.out_of_memory  = 1'b0;
                        done             = 1'b1;
                     end
                  end
               end
            end
         end
         // Free anywhere inside the frame; outside the region is flagged.
         CMD_FREE: begin
            idx = ({12'b0, addr} - shadow_base) / PAGE_BYTES;
            if ({12'b0, addr} < shadow_base || idx >= shadow_total) begin
               w.bad_free = 1'b1;
            end else begin
               shadow_map[idx >> 3][idx[2:0]] = 1'b0;
               if (shadow_used > 0) begin
                  shadow_used = shadow_used - 1;
               end
            end
         end
         default: begin
         end
      endcase
      w.used_frames = shadow_used[USED_W-1:0];
      return w;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endfunction

   // Sample both channels and the register port at the rising edge.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         for (int b = 0; b < MAP_BYTES; b++) begin
            shadow_map[b] = '0;
         end
         shadow_total = '0;
         shadow_used  = '0;
         shadow_base  = '0;
         shadow_end   = '0;
         pending_words.delete();
         error_count  = 0;
         open_words  <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_REGION_BASE: shadow_base = {12'b0, csr_wr_data};
               CSR_REGION_END:  shadow_end  = {12'b0, csr_wr_data};
               default: begin
               end
            endcase
         end
         // The response word always belongs to an older request word.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_words.size() == 0) begin
               $error("response word with no request word outstanding");
               error_count++;
            end else begin
               want = pending_words.pop_front();
               check_field("frame_address", 64'(want.frame_address),
                           64'(rsp_ch.frame_address));
               check_field("out_of_memory", 64'(want.out_of_memory),
                           64'(rsp_ch.out_of_memory));
               check_field("bad_free", 64'(want.bad_free), 64'(rsp_ch.bad_free));
               check_field("used_frames", 64'(want.used_frames),
                           64'(rsp_ch.used_frames));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_words.push_back(predict_response(cmd_type'(req_ch.command),
                                                     req_ch.free_address));
         end
         open_words <= pending_words.size();
      end
   end

endmodule

@@ tb/sv/page_frame_bitmap_allocator_test.sv @@
// ----------------------------------------------------------------------------
// Page frame bitmap allocator test
// Drives request words and region settings into the allocator, with random
// gaps on the request side and random stalls on the response side. A
// directed part covers empty, inverted, tiny and saturated regions and the
// free corner cases; random phases then mix allocations and frees over
// fresh regions. The checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_test;
   import pfba_pkg::*;

   localparam int                MAX_FRAMES = 65536;
   localparam int                PAGE_BYTES = 4096;
   localparam logic [ADDR_W-1:0] ADDR_MAX   = '1;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_wr_data;
   int                   error_count;
   int                   open_words;
   logic                 idle_on;

   // Region as last written, used to aim frees.
   logic [ADDR_W-1:0]    region_lo;
   logic [ADDR_W-1:0]    region_hi;
   int                   region_frames;

   pfba_req_if req_ch ();
   pfba_rsp_if rsp_ch ();

   page_frame_bitmap_allocator #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BYTES (PAGE_BYTES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   pfba_checker #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BYTES (PAGE_BYTES)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .error_count (error_count),
      .open_words  (open_words)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(64'd36_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Response side stalls in about one cycle of eight while idling is on.
   always @(negedge clock) begin
      rsp_ch.ready <= !idle_on || ($urandom_range(99) >= 12);
   end

   function automatic logic [ADDR_W-1:0] random_address();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[ADDR_W-1:0];
   endfunction

   // Offer one request word and hold it until the block takes it.
   task automatic send_word(cmd_type cmd, logic [ADDR_W-1:0] addr);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 12) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.free_address <= addr;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_reg(csr_index_type idx, logic [ADDR_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Let the block drain, then move it to a new region.
   task automatic set_region(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
      logic [ADDR_W-1:0] span;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (open_words != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      write_reg(CSR_REGION_BASE, lo);
      write_reg(CSR_REGION_END, hi);
      region_lo = lo;
      region_hi = hi;
      span      = (hi > lo) ? (hi - lo) / PAGE_BYTES : '0;
      region_frames = (span > MAX_FRAMES) ? MAX_FRAMES : int'(span);
   endtask

   initial begin
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] addr;
      int                kind;
      int                pick;

      reset               = 1'b1;
      idle_on             = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_REGION_BASE;
      csr_wr_data         = '0;
      req_ch.valid        = 1'b0;
      req_ch.command      = CMD_NOP;
      req_ch.free_address = '0;
      region_lo           = '0;
      region_hi           = '0;
      region_frames       = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Before any init there are no frames at all.
      send_word(CMD_ALLOC, '0);
      send_word(CMD_FREE, '0);
      send_word(CMD_NOP, ADDR_MAX);

      // Empty region, then end below base.
      set_region('0, '0);
      send_word(CMD_INIT, '0);
      send_word(CMD_ALLOC, '0);
      set_region(52'h0_0001_0000_0000, 52'h0_0000_0000_4000);
      send_word(CMD_INIT, '0);
      send_word(CMD_ALLOC, '0);

      // Nine frames with a tail past the last one and the top address bit set.
      base = 52'h8_0000_1234_5000;
      set_region(base, base + 9 * PAGE_BYTES + 100);
      send_word(CMD_INIT, '0);
      // Freeing the reserved frame while the count is zero.
      send_word(CMD_FREE, base);
      repeat (9) send_word(CMD_ALLOC, '0);
      // Map bits past the frame count are never handed out.
      send_word(CMD_ALLOC, '0);
      // Unaligned free, then the same frame again while already clear.
      send_word(CMD_FREE, base + 3 * PAGE_BYTES + 12'h7ff);
      send_word(CMD_FREE, base + 3 * PAGE_BYTES);
      send_word(CMD_FREE, base - 1);
      send_word(CMD_FREE, base + 9 * PAGE_BYTES);
      send_word(CMD_FREE, ADDR_MAX);

      // Whole address space saturates to the bitmap capacity.
      set_region('0, ADDR_MAX);
      send_word(CMD_INIT, '0);
      send_word(CMD_ALLOC, '0);
      send_word(CMD_FREE, ADDR_MAX);

      // Random phases: mostly small regions, some inverted, saturated or
      // right at the top of the address space.
      for (int phase = 0; phase < 9; phase++) begin
         idle_on = !(phase >= 3 && phase <= 5);
         kind    = (phase % 3 == 0) ? $urandom_range(1, 3) : 0;
         case (kind)
            0: begin
               base = random_address() % (ADDR_MAX - 52'h10_0000);
               if ($urandom_range(1)) begin
                  base[11:0] = '0;
               end
               set_region(base, base + ($urandom_range(1) ? $urandom_range(1, 16)
                                                          : $urandom_range(17, 120))
                                       * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1));
            end
            1: begin
               base = random_address() | 52'h8_0000_0000_0000;
               set_region(base, random_address() % base);
            end
            2: begin
               set_region(random_address() % 52'h4000_0000, ADDR_MAX);
            end
            default: begin
               set_region(ADDR_MAX - $urandom_range(0, 12) * PAGE_BYTES
                                   - $urandom_range(PAGE_BYTES - 1), ADDR_MAX);
            end
         endcase
         send_word(CMD_INIT, random_address());
         for (int n = 0; n < 7; n++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               send_word(CMD_ALLOC, random_address());
            end else if (pick < 80) begin
               // Somewhere inside a managed frame.
               addr = region_lo + ADDR_W'($urandom_range(region_frames > 0 ?
                                                         region_frames - 1 : 0))
                                * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1);
               send_word(CMD_FREE, addr);
            end else if (pick < 88) begin
               send_word(CMD_FREE, random_address());
            end else if (pick < 93) begin
               // Just outside the managed frames on either side.
               addr = $urandom_range(1) ? region_lo - 1
                                        : region_lo + ADDR_W'(region_frames) * PAGE_BYTES
                                          + $urandom_range(PAGE_BYTES - 1);
               send_word(CMD_FREE, addr);
            end else if (pick < 96) begin
               send_word(CMD_NOP, random_address());
            end else begin
               send_word(CMD_INIT, random_address());
            end
         end
      end

      // Drain the last words, then give the verdict.
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (open_words != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
